// ----- rtl/sap_pkg.sv -----
package sap_pkg;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FAIL     = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    localparam logic [1:0] CLASS_T0_6    = 2'd0;
    localparam logic [1:0] CLASS_T0_E    = 2'd1;
    localparam logic [1:0] CLASS_OTHER   = 2'd2;

    localparam logic [7:0] TS_DIRECT  = 8'h3B;
    localparam logic [7:0] TS_INVERSE = 8'h3F;
    localparam logic [3:0] T0_HI_6    = 4'h6;
    localparam logic [3:0] T0_HI_E    = 4'hE;
    localparam logic [7:0] TD1_EXPECT = 8'h81;
    localparam logic [7:0] TD2_EXPECT = 8'h31;

    localparam logic [1:0] Y_TD_BIT   = 2'd3;
    localparam logic [1:0] LAST_GROUP = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] card_class;
        logic [4:0] atr_length;
    } sap_result_t;

endpackage

// ----- rtl/sap_parser.sv -----
module sap_parser
    import sap_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [1:0]  kind,
    input  logic [7:0]  data,
    output logic        res_valid,
    output sap_result_t res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TS,
        PH_T0,
        PH_IFACE,
        PH_HIST,
        PH_TCK
    } phase_t;

    phase_t     phase_reg,   phase_next;
    logic [3:0] pend_reg,    pend_next;
    logic [1:0] group_reg,   group_next;
    logic [3:0] hist_reg,    hist_next;
    logic [7:0] xor_reg,     xor_next;
    logic [1:0] class_reg,   class_next;
    logic [4:0] count_reg,   count_next;
    logic [1:0] sel_bit;

    always_comb begin
        if (pend_reg[0]) begin
            sel_bit = 2'd0;
        end else if (pend_reg[1]) begin
            sel_bit = 2'd1;
        end else if (pend_reg[2]) begin
            sel_bit = 2'd2;
        end else begin
            sel_bit = 2'd3;
        end
    end

    always_comb begin
        logic after_iface;
        logic [1:0] emit_status;
        phase_next  = phase_reg;
        pend_next   = pend_reg;
        group_next  = group_reg;
        hist_next   = hist_reg;
        xor_next    = xor_reg;
        class_next  = class_reg;
        count_next  = count_reg;
        res_valid   = 1'b0;
        after_iface = 1'b0;
        emit_status = STATUS_OK;

        if (kind == KIND_START) begin
            phase_next = PH_TS;
            pend_next  = '0;
            group_next = '0;
            hist_next  = '0;
            xor_next   = '0;
            class_next = '0;
            count_next = '0;
        end else if (phase_reg != PH_IDLE && kind == KIND_FAIL) begin
            res_valid   = 1'b1;
            emit_status = STATUS_FAIL;
        end else if (phase_reg != PH_IDLE && kind == KIND_BYTE) begin
            count_next = count_reg + 5'd1;
            case (phase_reg)
                PH_TS: begin
                    if (data != TS_DIRECT && data != TS_INVERSE) begin
                        res_valid   = 1'b1;
                        emit_status = STATUS_FAIL;
                    end else begin
                        phase_next = PH_T0;
                    end
                end
                PH_T0: begin
                    xor_next = data;
                    if (data[7:4] == T0_HI_6) begin
                        class_next = CLASS_T0_6;
                    end else if (data[7:4] == T0_HI_E) begin
                        class_next = CLASS_T0_E;
                    end else begin
                        class_next = CLASS_OTHER;
                    end
                    pend_next  = data[7:4];
                    group_next = '0;
                    hist_next  = data[3:0];
                    if (data[7:4] != 4'd0) begin
                        phase_next = PH_IFACE;
                    end else begin
                        after_iface = 1'b1;
                    end
                end
                PH_IFACE: begin
                    xor_next = xor_reg ^ data;
                    pend_next = pend_reg & ~(4'd1 << sel_bit);
                    if (sel_bit == Y_TD_BIT) begin
                        if (group_reg == 2'd0 && data != TD1_EXPECT) begin
                            class_next = CLASS_OTHER;
                        end
                        if (group_reg == 2'd1 && data != TD2_EXPECT) begin
                            class_next = CLASS_OTHER;
                        end
                        if (group_reg < LAST_GROUP) begin
                            pend_next  = data[7:4];
                            group_next = group_reg + 2'd1;
                        end else begin
                            pend_next = '0;
                        end
                    end
                    if (pend_next == 4'd0) begin
                        after_iface = 1'b1;
                    end
                end
                PH_HIST: begin
                    xor_next = xor_reg ^ data;
                    if (hist_reg != 4'd0) begin
                        hist_next = hist_reg - 4'd1;
                    end
                    if (hist_next == 4'd0) begin
                        after_iface = 1'b1;
                    end
                end
                PH_TCK: begin
                    res_valid   = 1'b1;
                    emit_status = (data == xor_reg) ? STATUS_OK : STATUS_MISMATCH;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (after_iface) begin
            if (hist_next != 4'd0) begin
                phase_next = PH_HIST;
            end else if (class_next == CLASS_T0_E) begin
                phase_next = PH_TCK;
            end else begin
                res_valid   = 1'b1;
                emit_status = STATUS_OK;
            end
        end

        if (res_valid) begin
            phase_next = PH_IDLE;
        end

        res.status     = emit_status;
        res.card_class = class_next;
        res.atr_length = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pend_reg  <= '0;
            group_reg <= '0;
            hist_reg  <= '0;
            xor_reg   <= '0;
            class_reg <= '0;
            count_reg <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            group_reg <= group_next;
            hist_reg  <= hist_next;
            xor_reg   <= xor_next;
            class_reg <= class_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/smartcard_atr_parser.sv -----
// Answer-to-reset parser. Each request carries one event of the card link: a start of a new
// answer, one received byte, or a receive failure. A start clears the parser; bytes are then
// checked as TS, T0, the interface groups, the historical bytes and, for class 1 cards, TCK.
// One verdict (status, card class, byte count) is delivered as soon as the last expected byte
// or a failure arrives; events outside an answer give no verdict. The block takes one request
// per clock: a request is registered at the input, processed by the parser and its verdict
// registered at the output. Only a stalled output register holds up the input.
module smartcard_atr_parser
    import sap_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [1:0] m_card_class,
    output logic [4:0] m_atr_length
);

    logic        in_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  data_reg;
    logic        out_valid_reg;
    sap_result_t out_reg;
    logic        proc_fire;
    logic        res_valid;
    sap_result_t res;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;

    sap_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (proc_fire),
        .kind      (kind_reg),
        .data      (data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= s_kind;
            data_reg <= s_data;
        end
        if (proc_fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_reg.status;
    assign m_card_class = out_reg.card_class;
    assign m_atr_length = out_reg.atr_length;

endmodule
